>>> hdl/sns_pkg.sv
// Shared types and constants for the sorted note stack.
`timescale 1ns / 1ps

package sns_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int NOTE_W    = 7;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int STATUS_W  = 2;

  typedef logic [NOTE_W-1:0]   note_t;
  typedef logic [SLOT_W-1:0]   slot_idx_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam slot_idx_t LAST_SLOT = slot_idx_t'(NUM_SLOTS - 1);

  // Operation codes carried on the input tuser.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Result status codes.
  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_PRESENT = 2'd1;
  localparam status_t ST_DROPPED = 2'd2;
  localparam status_t ST_MISSING = 2'd3;

  // Flags produced by the shared slot comparator.
  typedef struct packed {
    logic empty;
    logic equal;
    logic at_or_above;
  } cmp_t;

endpackage

>>> hdl/sns_cmp.sv
// Shared comparator that checks one held slot against the note being processed.
`timescale 1ns / 1ps

module sns_cmp (
  input  sns_pkg::note_t held,
  input  sns_pkg::note_t note,
  output sns_pkg::cmp_t  flags
);
  import sns_pkg::*;

  always_comb begin
    flags.empty       = (held == '0);
    flags.equal       = (held == note);
    flags.at_or_above = (held >= note);
  end

endmodule

>>> hdl/sorted_note_stack_top.sv
// Sorted four-slot note stack: top level with the scan sequencer and slot registers.
//
// The block keeps up to four notes in ascending order, zero marking an empty slot.
// Each input transfer on the s_ channel carries an operation on s_tuser (push or
// pop) and a note number in s_tdata. Each input transfer yields exactly one output
// transfer on the m_ channel: the status on m_tuser and all four slots, as they
// stand after the operation, on m_tdata.
// One comparator is shared across the slots; the sequencer visits one slot per
// cycle and stops at the insertion point for a push, or after the last slot for
// a pop. A note of zero skips the scan. The next item can be taken in the same
// cycle in which the previous result raises m_tvalid.
// s_tready is high only while no item is in work. If the receiver stalls, the
// finished result waits in a holding step and the output register stays put;
// no further input is taken until the result has been loaded for transfer.
// Synchronous reset empties all slots and drops any pending result.
`timescale 1ns / 1ps

module sorted_note_stack_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [6:0] note, [7] zero
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [6:0] slot_0, [13:7] slot_1, [20:14] slot_2,
                                 // [27:21] slot_3, [31:28] zero
  output logic [1:0]  m_tuser    // [1:0] status
);
  import sns_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state, state_next;
  slot_idx_t  idx, idx_next;
  logic       func_r;
  note_t      note_r;
  status_t    status_r, status_next;
  logic       found, found_next;
  note_t      slots [NUM_SLOTS];
  note_t      slots_next [NUM_SLOTS];
  cmp_t       cmp;
  logic       in_xfer, out_free;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  sns_cmp u_cmp (
    .held  (slots[idx]),
    .note  (note_r),
    .flags (cmp)
  );

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    status_next = status_r;
    found_next  = found;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      slots_next[j] = slots[j];
    end

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          idx_next   = '0;
          found_next = 1'b0;
          // A zero note leaves the stack alone and reports at once.
          if (s_tdata[NOTE_W-1:0] == '0) begin
            status_next = (s_tuser == FUNC_POP) ? ST_MISSING : ST_DONE;
            state_next  = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (func_r == FUNC_PUSH) begin
          if (!cmp.empty && cmp.equal) begin
            status_next = ST_PRESENT;
            state_next  = S_FINISH;
          end else if (cmp.empty || cmp.at_or_above) begin
            for (int j = 1; j < NUM_SLOTS; j++) begin
              if (slot_idx_t'(j) > idx) begin
                slots_next[j] = slots[j-1];
              end
            end
            slots_next[idx] = note_r;
            status_next     = ST_DONE;
            state_next      = S_FINISH;
          end else if (idx == LAST_SLOT) begin
            status_next = ST_DROPPED;
            state_next  = S_FINISH;
          end else begin
            idx_next = idx + slot_idx_t'(1);
          end
        end else begin
          // Removal closes the gap; the scan still moves on to the next slot.
          if (cmp.equal) begin
            for (int j = 0; j < NUM_SLOTS - 1; j++) begin
              if (slot_idx_t'(j) >= idx) begin
                slots_next[j] = slots[j+1];
              end
            end
            slots_next[NUM_SLOTS-1] = '0;
            found_next = 1'b1;
          end
          if (idx == LAST_SLOT) begin
            status_next = (found || cmp.equal) ? ST_DONE : ST_MISSING;
            state_next  = S_FINISH;
          end else begin
            idx_next = idx + slot_idx_t'(1);
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        slots[j] <= '0;
      end
    end else begin
      state <= state_next;
      idx   <= idx_next;
      found <= found_next;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        slots[j] <= slots_next[j];
      end
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_next;
    if (in_xfer) begin
      func_r <= s_tuser;
      note_r <= s_tdata[NOTE_W-1:0];
    end
    if (state == S_FINISH && out_free) begin
      m_tuser <= status_r;
      m_tdata <= {4'b0000, slots[3], slots[2], slots[1], slots[0]};
    end
  end

  // Held notes stay packed at the low slots.
  a_compact : assert property (@(posedge clk) disable iff (rst)
    (slots[0] != '0 || slots[1] == '0) && (slots[1] != '0 || slots[2] == '0) &&
    (slots[2] != '0 || slots[3] == '0))
    else $error("note stack has a gap");

  // A full stack holds its notes in strictly ascending order.
  a_sorted : assert property (@(posedge clk) disable iff (rst)
    (slots[3] != '0) |-> (slots[0] < slots[1]) && (slots[1] < slots[2]) &&
                         (slots[2] < slots[3]))
    else $error("full note stack out of order");

  // A dropped push is only reported with every slot occupied.
  a_drop_full : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_DROPPED) |->
      (m_tdata[6:0] != '0) && (m_tdata[13:7] != '0) &&
      (m_tdata[20:14] != '0) && (m_tdata[27:21] != '0))
    else $error("drop reported with a free slot");

  // A nonzero note always starts its scan at the lowest slot.
  a_scan_start : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_tdata[NOTE_W-1:0] != '0) |=> (state == S_SCAN && idx == '0))
    else $error("scan did not start at slot zero");

endmodule

>>> tb/sv/sorted_note_stack_top_test.sv
// Self-checking testbench for the sorted four-slot note stack.
`timescale 1ns / 1ps

module sorted_note_stack_top_test;
  import sns_pkg::*;

  typedef logic [NUM_SLOTS-1:0][NOTE_W-1:0] stack_t;

  typedef struct packed {
    logic  func;
    note_t note;
  } note_op_t;

  typedef struct packed {
    status_t status;
    stack_t  slots;
  } slot_result_t;

  localparam int RANDOM_OPS = 1700;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  note_op_t     note_ops_pending[$];
  slot_result_t expected_results[$];
  stack_t       gen_stack   = '0;  // stack contents as the generator leaves them
  stack_t       model_stack = '0;  // stack contents after every accepted transfer
  slot_result_t queued;
  slot_result_t want;
  int           total_ops    = 1;
  int           ops_accepted = 0;
  int           results_seen = 0;
  int           fail_count   = 0;
  int           tx_idle_pct;
  int           rx_idle_pct;

  sorted_note_stack_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Applies one push or pop to a stack and returns the status it reports.
  function automatic status_t apply_note_op(inout stack_t st, input logic op, input note_t n);
    status_t res;
    logic    placed;
    int      i;
    int      j;
    placed = 1'b0;
    if (op == FUNC_PUSH) begin
      res = ST_DROPPED;
      if (n == '0) begin
        res = ST_DONE;
        placed = 1'b1;
      end
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (!placed) begin
          if (st[i] != '0 && st[i] == n) begin
            res = ST_PRESENT;
            placed = 1'b1;
          end else if (st[i] == '0 || st[i] >= n) begin
            for (j = NUM_SLOTS - 1; j > i; j--)
              st[j] = st[j-1];
            st[i] = n;
            res = ST_DONE;
            placed = 1'b1;
          end
        end
      end
    end else begin
      res = ST_MISSING;
      if (n != '0) begin
        // The scan goes on after a removal, just as the hardware scans every slot.
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (st[i] == n) begin
            for (j = i; j < NUM_SLOTS - 1; j++)
              st[j] = st[j+1];
            st[NUM_SLOTS-1] = '0;
            res = ST_DONE;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic int held_count(input stack_t st);
    int i;
    int cnt;
    cnt = 0;
    for (i = 0; i < NUM_SLOTS; i++)
      if (st[i] != '0)
        cnt++;
    return cnt;
  endfunction

  task automatic queue_op(input logic op, input note_t n);
    note_op_t item;
    status_t  ignored;
    item.func = op;
    item.note = n;
    note_ops_pending.push_back(item);
    ignored = apply_note_op(gen_stack, op, n);
  endtask

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10)
      $display("%s", what);
  endtask

  // Sender: presents the next pending operation unless it idles this cycle.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        queued.status = apply_note_op(model_stack, s_tuser, s_tdata[NOTE_W-1:0]);
        queued.slots  = model_stack;
        expected_results.push_back(queued);
        ops_accepted++;
      end
      case (ops_accepted * 3 / total_ops)
        0:       tx_idle_pct = 13;
        1:       tx_idle_pct = 61;
        default: tx_idle_pct = 0;
      endcase
      if (!s_tvalid || s_tready) begin
        if (note_ops_pending.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, note_ops_pending[0].note};
          s_tuser  <= note_ops_pending[0].func;
          note_ops_pending.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every output transfer against the oldest expected result.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d slots %h", m_tuser, m_tdata));
        end else begin
          want = expected_results.pop_front();
          if (m_tuser !== want.status)
            note_failure($sformatf("result %0d: status expected %0d, got %0d",
                                   results_seen, want.status, m_tuser));
          for (int i = 0; i < NUM_SLOTS; i++)
            if (m_tdata[NOTE_W*i +: NOTE_W] !== want.slots[i])
              note_failure($sformatf("result %0d: slot_%0d expected %0d, got %0d",
                                     results_seen, i, want.slots[i],
                                     m_tdata[NOTE_W*i +: NOTE_W]));
        end
      end
      case (results_seen * 3 / total_ops)
        0:       rx_idle_pct = 61;
        1:       rx_idle_pct = 13;
        default: rx_idle_pct = 0;
      endcase
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  initial begin : stimulus
    int    r;
    int    nheld;
    note_t n;

    // Fill up, hit duplicates, drop from a full stack and empty it again.
    queue_op(FUNC_PUSH, 7'd64);
    queue_op(FUNC_PUSH, 7'd1);
    queue_op(FUNC_PUSH, 7'd127);
    queue_op(FUNC_PUSH, 7'd64);
    queue_op(FUNC_PUSH, 7'd32);
    queue_op(FUNC_PUSH, 7'd127);
    queue_op(FUNC_PUSH, 7'd100);
    queue_op(FUNC_PUSH, 7'd127);
    queue_op(FUNC_PUSH, 7'd1);
    queue_op(FUNC_POP,  7'd50);
    queue_op(FUNC_POP,  7'd1);
    queue_op(FUNC_POP,  7'd100);
    queue_op(FUNC_POP,  7'd100);
    queue_op(FUNC_PUSH, 7'd127);
    queue_op(FUNC_PUSH, 7'h55);
    queue_op(FUNC_PUSH, 7'h2a);
    queue_op(FUNC_POP,  7'd32);
    queue_op(FUNC_POP,  7'd64);
    queue_op(FUNC_POP,  7'd127);
    queue_op(FUNC_POP,  7'h55);
    queue_op(FUNC_POP,  7'h2a);
    queue_op(FUNC_POP,  7'd1);

    // Random part: mostly pops of held notes and pushes that collide or reorder.
    for (int k = 0; k < RANDOM_OPS; k++) begin
      r = $urandom_range(0, 99);
      nheld = held_count(gen_stack);
      if (nheld > 0 && r < 35) begin
        queue_op(FUNC_POP, gen_stack[$urandom_range(0, nheld - 1)]);
      end else if (r < 45) begin
        queue_op(FUNC_POP, note_t'($urandom_range(1, 127)));
      end else if (nheld > 0 && r < 55) begin
        queue_op(FUNC_PUSH, gen_stack[$urandom_range(0, nheld - 1)]);
      end else if (r < 70) begin
        n = note_t'($urandom_range(60, 67));
        queue_op(FUNC_PUSH, n);
      end else begin
        queue_op(FUNC_PUSH, note_t'($urandom_range(1, 127)));
      end
    end
    total_ops = note_ops_pending.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (note_ops_pending.size() > 0 || s_tvalid)
      @(posedge clk);
    while (expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("** sorted_note_stack_top: PASSED **");
    end else begin
      $display("** sorted_note_stack_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** sorted_note_stack_top: FAILED **");
    $finish;
  end

endmodule
